FILE: rtl/core/utmm_pkg.sv
// Shared types, action codes and the packed column base function for the triangular multiply unit.
`timescale 1ns / 1ps

package utmm_pkg;

    localparam logic [1:0] ACT_DENSE   = 2'd0;
    localparam logic [1:0] ACT_TRI     = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    localparam logic REG_MATRIX_SIZE = 1'b0;
    localparam logic [4:0] MATRIX_SIZE_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [15:0] entry_value;
    } t_in_word;

    typedef struct packed {
        logic signed [39:0] product_value;
        logic [3:0]         product_row;
        logic [3:0]         product_col;
    } t_out_word;

    // Start of column x in the packed triangle: x*(x+1)/2.
    function automatic logic [7:0] tri_base(input logic [3:0] x);
        logic [8:0] p;
        p = {5'b0, x} * ({5'b0, x} + 9'd1);
        return p[8:1];
    endfunction

endpackage

FILE: rtl/core/upper_triangular_matrix_multiply_unit.sv
// Top level: dense and packed triangular stores with a shared multiply-accumulate sequencer.
`timescale 1ns / 1ps

// Write items (dense or triangular entry) finish in the cycle they are accepted and never
// raise busy. A compute item keeps busy high while it reads, multiplies and accumulates, and
// its word appears on o_out_word with o_result_valid in the first cycle in which busy is low.
// The run length is set by the single multiplier and the one read port of each store, which
// deliver one product per cycle. The result strobe lasts one cycle and cannot be held off, so
// the receiver must take every word when it appears. Entries must be written before a compute
// reads them; the stores have no reset value.
module upper_triangular_matrix_multiply_unit
    import utmm_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_word    i_in_word,
    output logic        o_result_valid,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DENSE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int TRI_DEPTH   = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int DA_W        = $clog2(DENSE_DEPTH);
    localparam int TA_W        = $clog2(TRI_DEPTH);
    localparam int NW          = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [4:0]         r_matrix_size;
    logic [NW-1:0]      dim;
    logic               in_range;
    logic               accept;

    logic [15:0]        dense_mem [DENSE_DEPTH];
    logic [15:0]        tri_mem   [TRI_DEPTH];
    logic [DA_W-1:0]    dense_waddr, dense_raddr;
    logic [TA_W-1:0]    tri_waddr, tri_raddr;

    logic [3:0]         r_row, r_col, r_k;
    logic               r_v1, r_l1, r_v2, r_l2;
    logic signed [15:0] r_m_rd, r_u_rd;
    logic signed [31:0] r_prod;
    logic signed [39:0] r_acc;
    logic signed [39:0] acc_sum;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {27'b0, r_matrix_size} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= MATRIX_SIZE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MATRIX_SIZE) begin
            r_matrix_size <= pwdata[4:0];
        end
    end

    // Size in effect, clamped to 1..MAX_DIM.
    always_comb begin
        if (r_matrix_size == 5'd0) begin
            dim = NW'(1);
        end else if (32'(r_matrix_size) > MAX_DIM) begin
            dim = NW'(MAX_DIM);
        end else begin
            dim = NW'(r_matrix_size);
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(i_in_word.row_index) < 32'(dim))
                   && (32'(i_in_word.col_index) < 32'(dim));

    assign dense_waddr = DA_W'(32'(i_in_word.row_index) * MAX_DIM
                               + 32'(i_in_word.col_index));
    assign tri_waddr   = TA_W'(32'(tri_base(i_in_word.col_index))
                               + 32'(i_in_word.row_index));
    assign dense_raddr = DA_W'(32'(r_row) * MAX_DIM + 32'(r_k));
    assign tri_raddr   = TA_W'(32'(tri_base(r_col)) + 32'(r_k));

    // Stores: one write port driven by load words, one registered read port for the sequencer.
    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_in_word.action == ACT_DENSE) begin
            dense_mem[dense_waddr] <= i_in_word.entry_value;
        end
        r_m_rd <= dense_mem[dense_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_in_word.action == ACT_TRI
            && i_in_word.row_index <= i_in_word.col_index) begin
            tri_mem[tri_waddr] <= i_in_word.entry_value;
        end
        r_u_rd <= tri_mem[tri_raddr];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && in_range && i_in_word.action == ACT_COMPUTE) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_k == r_col) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_v2 && r_l2) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign acc_sum = r_acc + {{8{r_prod[31]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_v1           <= (r_state == S_RUN);
            r_v2           <= r_v1;
            o_result_valid <= r_v2 && r_l2;
        end
    end

    // Datapath: read, multiply, accumulate, one product per cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_in_word.row_index;
            r_col <= i_in_word.col_index;
            r_k   <= 4'd0;
            r_acc <= 40'sd0;
        end else begin
            if (r_state == S_RUN && r_k != r_col) begin
                r_k <= r_k + 4'd1;
            end
            if (r_v2) begin
                r_acc <= acc_sum;
            end
        end
        r_l1   <= (r_k == r_col);
        r_l2   <= r_l1;
        r_prod <= r_m_rd * r_u_rd;
        if (r_v2 && r_l2) begin
            o_out_word.product_value <= acc_sum;
            o_out_word.product_row   <= r_row;
            o_out_word.product_col   <= r_col;
        end
    end

    // A compute passes through the run and drain states before its result, so result strobes never touch.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> (r_state != S_IDLE))
        else $error("product pipeline active while sequencer idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_range && i_in_word.action == ACT_COMPUTE) |=> busy)
        else $error("compute word accepted without raising busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_v2 && r_l2))
        else $error("result word without a final product");

endmodule

FILE: tb/utmm_product_checker.sv
// Checker for the triangular multiply unit: it tracks stores and size and compares every result word.
`timescale 1ns / 1ps

module utmm_product_checker
    import utmm_pkg::*;
#(
    parameter int MAX_DIM = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_in_word    i_in_word,
    input  logic        o_result_valid,
    input  t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          products_pending
);

    logic signed [15:0] dense_mem [MAX_DIM * MAX_DIM];
    logic signed [15:0] tri_mem   [MAX_DIM * (MAX_DIM + 1) / 2];
    logic [4:0]         size_reg = MATRIX_SIZE_RESET;
    t_out_word          awaited_products [$];

    // Column c of the packed triangle begins after the c shorter columns to its left.
    function automatic int column_start(input int c);
        return c * (c + 1) / 2;
    endfunction

    function automatic int active_dim(input logic [4:0] s);
        if (s == 5'd0) begin
            return 1;
        end
        if (s > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(s);
    endfunction

    function automatic logic signed [39:0] dot_product_entry(input int r, input int c);
        longint acc;
        acc = 0;
        for (int k = 0; k <= c; k++) begin
            acc += longint'(dense_mem[r * MAX_DIM + k]) * longint'(tri_mem[column_start(c) + k]);
        end
        return acc[39:0];
    endfunction

    function automatic void record_word(input t_in_word w);
        int        r;
        int        c;
        t_out_word want;
        r = int'(w.row_index);
        c = int'(w.col_index);
        // Anything addressed outside the active square is dropped, computes included.
        if (r >= active_dim(size_reg) || c >= active_dim(size_reg)) begin
            return;
        end
        case (w.action)
            ACT_DENSE: begin
                dense_mem[r * MAX_DIM + c] = w.entry_value;
            end
            ACT_TRI: begin
                if (r <= c) begin
                    tri_mem[column_start(c) + r] = w.entry_value;
                end
            end
            ACT_COMPUTE: begin
                want.product_value = dot_product_entry(r, c);
                want.product_row   = w.row_index;
                want.product_col   = w.col_index;
                awaited_products.push_back(want);
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            size_reg = MATRIX_SIZE_RESET;
            awaited_products.delete();
            mismatch_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
                    && paddr[2] == REG_MATRIX_SIZE) begin
                size_reg = pwdata[4:0];
            end
            if (o_result_valid) begin
                if (awaited_products.size() == 0) begin
                    $error("result word row %0d col %0d value %0d with none awaited",
                           o_out_word.product_row, o_out_word.product_col,
                           o_out_word.product_value);
                    mismatch_count++;
                end else begin
                    want = awaited_products.pop_front();
                    if (o_out_word.product_value !== want.product_value) begin
                        $error("product_value: expected %0d, got %0d",
                               want.product_value, o_out_word.product_value);
                        mismatch_count++;
                    end
                    if (o_out_word.product_row !== want.product_row) begin
                        $error("product_row: expected %0d, got %0d",
                               want.product_row, o_out_word.product_row);
                        mismatch_count++;
                    end
                    if (o_out_word.product_col !== want.product_col) begin
                        $error("product_col: expected %0d, got %0d",
                               want.product_col, o_out_word.product_col);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                record_word(i_in_word);
            end
        end
        products_pending <= awaited_products.size();
    end

endmodule

FILE: tb/upper_triangular_matrix_multiply_unit_tb.sv
// Testbench top: clock, reset, stimulus and register writes for the triangular multiply unit.
`timescale 1ns / 1ps

module upper_triangular_matrix_multiply_unit_tb;
    import utmm_pkg::*;

    localparam int         MAX_DIM      = 16;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic       REG_UNMAPPED = 1'b1;
    localparam int         PHASE_ITEMS  = 140;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         CYCLE_LIMIT  = 500000;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_in_word    i_in_word = '0;
    logic        o_result_valid;
    t_out_word   o_out_word;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int products_pending;
    int cycle_count = 0;

    // Stimulus-side view: which entries hold data, and the active dimension.
    bit dense_written [MAX_DIM][MAX_DIM];
    bit tri_written   [MAX_DIM][MAX_DIM];
    int dim = MAX_DIM;
    int burst_left = 0;
    int effective_items = 0;
    int size_plan [9] = '{0, 1, 2, 31, 7, 17, 16, 11, 3};

    upper_triangular_matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_in_word     (i_in_word),
        .o_result_valid(o_result_valid),
        .o_out_word    (o_out_word),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    utmm_product_checker #(.MAX_DIM(MAX_DIM)) product_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_in_word       (i_in_word),
        .o_result_valid  (o_result_valid),
        .o_out_word      (o_out_word),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .products_pending(products_pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("upper_triangular_matrix_multiply_unit_tb failed");
            $finish;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Sends one word in bursts with random gaps, and returns once the block has taken it.
    task automatic send_item(input logic [1:0] act, input int r, input int c,
                             input logic [15:0] v);
        t_in_word w;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        w.action      = act;
        w.row_index   = 4'(r);
        w.col_index   = 4'(c);
        w.entry_value = v;
        start     <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (busy);
        if (act != ACT_UNUSED && r < dim && c < dim && !(act == ACT_TRI && r > c)) begin
            effective_items++;
            if (act == ACT_DENSE) begin
                dense_written[r][c] = 1'b1;
            end else if (act == ACT_TRI) begin
                tri_written[r][c] = 1'b1;
            end
        end
    endtask

    // Writes whatever the dot product for (r, c) still lacks, then asks for it.
    task automatic request_product(input int r, input int c);
        for (int k = 0; k <= c; k++) begin
            if (!dense_written[r][k]) begin
                send_item(ACT_DENSE, r, k, pick_value());
            end
            if (!tri_written[k][c]) begin
                send_item(ACT_TRI, k, c, pick_value());
            end
        end
        send_item(ACT_COMPUTE, r, c, 16'($urandom));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (products_pending != 0) @(posedge i_clk);
        // Writes and ignored words give no result, so a compute may still be running.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_matrix_size(input int s);
        apb_write({REG_MATRIX_SIZE, 2'b00}, {27'($urandom), 5'(s)});
        dim = (s == 0) ? 1 : (s > MAX_DIM) ? MAX_DIM : s;
    endtask

    task automatic run_random_phase();
        int target;
        int sel;
        int r;
        int c;
        int t;
        target = effective_items + PHASE_ITEMS;
        while (effective_items < target) begin
            sel = $urandom_range(0, 99);
            r = $urandom_range(0, dim - 1);
            c = $urandom_range(0, dim - 1);
            if (sel < 45) begin
                request_product(r, c);
            end else if (sel < 65) begin
                send_item(ACT_DENSE, r, c, pick_value());
            end else if (sel < 80) begin
                if (r > c) begin
                    t = r; r = c; c = t;
                end
                send_item(ACT_TRI, r, c, pick_value());
            end else if (sel < 86) begin
                // Below the diagonal the triangle keeps its contents.
                if (r < c) begin
                    t = r; r = c; c = t;
                end
                send_item(ACT_TRI, r, c, pick_value());
            end else if (sel < 94 && dim < MAX_DIM) begin
                if ($urandom_range(0, 1) == 1) begin
                    r = $urandom_range(dim, MAX_DIM - 1);
                end else begin
                    c = $urandom_range(dim, MAX_DIM - 1);
                end
                send_item(2'($urandom_range(0, 3)), r, c, pick_value());
            end else begin
                send_item(ACT_UNUSED, $urandom_range(0, MAX_DIM - 1),
                          $urandom_range(0, MAX_DIM - 1), pick_value());
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-scale operands give the largest and most negative single products.
        send_item(ACT_DENSE, 0, 0, 16'h8000);
        send_item(ACT_TRI, 0, 0, 16'h8000);
        request_product(0, 0);
        send_item(ACT_DENSE, 0, 0, 16'h7FFF);
        request_product(0, 0);
        send_item(ACT_TRI, 1, 0, 16'h1234);
        request_product(0, 0);
        send_item(ACT_DENSE, 15, 0, 16'hFFFF);
        request_product(15, 0);
        send_item(ACT_TRI, 0, 1, 16'h8000);
        send_item(ACT_TRI, 1, 1, 16'h7FFF);
        send_item(ACT_DENSE, 0, 1, 16'h8000);
        request_product(0, 1);
        send_item(ACT_UNUSED, 15, 15, 16'hFFFF);
        send_item(ACT_TRI, 15, 15, 16'h7FFF);
        send_item(ACT_DENSE, 15, 15, 16'h8000);
        request_product(15, 15);

        run_random_phase();
        foreach (size_plan[i]) begin
            drain_results();
            if (size_plan[i] == 7) begin
                apb_write({REG_UNMAPPED, 2'b00}, $urandom);
            end
            set_matrix_size(size_plan[i]);
            run_random_phase();
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("upper_triangular_matrix_multiply_unit_tb passed");
        end else begin
            $display("upper_triangular_matrix_multiply_unit_tb failed");
        end
        $finish;
    end

endmodule
